[sv/momentum_sgd_update_assert.svh]
// Assertion macros for the update block and its checker.
`ifndef MOMENTUM_SGD_UPDATE_ASSERT_SVH
`define MOMENTUM_SGD_UPDATE_ASSERT_SVH

// a implies c at the next edge, masked during reset
`define MSGD_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

// a implies c at the same edge, checked during reset too
`define MSGD_ASSERT_NOW(lbl, clk, a, c) \
   lbl: assert property (@(posedge clk) (a) |-> (c)) \
      else $error("assertion failed");

// a implies c at the next edge, checked during reset too
`define MSGD_ASSERT_AFTER(lbl, clk, a, c) \
   lbl: assert property (@(posedge clk) (a) |=> (c)) \
      else $error("assertion failed");

`endif

[sv/msgd_pkg.sv]
package msgd_pkg;

   localparam int COEF_W = 26;

   typedef enum logic [2:0] {
      REG_STEP_SIZE      = 3'd0,
      REG_DECAY_FACTOR   = 3'd1,
      REG_MOMENTUM_GAMMA = 3'd2,
      REG_NESTEROV_MODE  = 3'd3,
      REG_BATCH_COUNT    = 3'd4
   } csr_index_type;

   localparam logic [16:0] RST_STEP_SIZE      = 17'd655;
   localparam logic [16:0] RST_DECAY_FACTOR   = 17'd0;
   localparam logic [16:0] RST_MOMENTUM_GAMMA = 17'd58982;
   localparam logic [15:0] RST_BATCH_COUNT    = 16'd1;

   typedef struct packed {
      logic               is_bias;
      logic [11:0]        elem_index;
      logic signed [31:0] param_value;
      logic signed [31:0] grad_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] updated_value;
      logic [11:0]        out_index;
   } rsp_type;

   typedef struct packed {
      req_type     req;
      logic [15:0] slot;
   } item_type;

   typedef struct packed {
      logic [16:0]       step_size;
      logic [16:0]       momentum_gamma;
      logic [COEF_W-1:0] decay_coef;
      logic [16:0]       gamma_per_batch;
      logic [16:0]       rate_per_batch;
      logic [15:0]       batch_count;
      logic              nesterov_mode;
   } coef_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

[sv/msgd_front.sv]
module msgd_front #(
   parameter int WEIGHT_ENTRIES = 4096,
   parameter int BIAS_ENTRIES   = 256,
   parameter int FRAC_BITS      = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  msgd_pkg::req_type  req_data,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [16:0]        csr_wdata,
   input  logic               queue_full,
   input  logic               clear_busy,
   output logic               push,
   output msgd_pkg::item_type push_item,
   output msgd_pkg::coef_type coef
);

   localparam int CW = msgd_pkg::COEF_W;
   localparam logic [16:0] W_MOD = 17'(WEIGHT_ENTRIES);
   localparam logic [16:0] B_MOD = 17'(BIAS_ENTRIES);
   localparam int W_SH = 12 + $clog2(WEIGHT_ENTRIES);
   localparam int B_SH = 12 + $clog2(BIAS_ENTRIES);
   localparam logic [13:0] W_MUL = 14'(((longint'(1) << W_SH) + longint'(WEIGHT_ENTRIES) - 1)
                                       / longint'(WEIGHT_ENTRIES));
   localparam logic [13:0] B_MUL = 14'(((longint'(1) << B_SH) + longint'(BIAS_ENTRIES) - 1)
                                       / longint'(BIAS_ENTRIES));

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type   state_ff, state_in;
   logic        dirty_ff, dirty_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [16:0] lr_ff, wd_ff, gam_ff;
   logic        nest_ff;
   logic [15:0] bs_ff;
   logic [15:0] bs_eff;
   logic [33:0] lw_prod;
   logic [CW-1:0] dvd_ff[3];
   logic [CW-1:0] dvd_in[3];
   logic [15:0]   rem_ff[3];
   logic [15:0]   rem_in[3];
   logic [16:0]   slot_wide;
   logic [25:0]   w_prod, b_prod;
   logic [11:0]   w_quot, b_quot;
   logic [16:0]   w_slot, b_slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff   <= msgd_pkg::RST_STEP_SIZE;
         wd_ff   <= msgd_pkg::RST_DECAY_FACTOR;
         gam_ff  <= msgd_pkg::RST_MOMENTUM_GAMMA;
         nest_ff <= 1'b0;
         bs_ff   <= msgd_pkg::RST_BATCH_COUNT;
      end else if (csr_we) begin
         unique case (msgd_pkg::csr_index_type'(csr_index))
            msgd_pkg::REG_STEP_SIZE:      lr_ff   <= csr_wdata;
            msgd_pkg::REG_DECAY_FACTOR:   wd_ff   <= csr_wdata;
            msgd_pkg::REG_MOMENTUM_GAMMA: gam_ff  <= csr_wdata;
            msgd_pkg::REG_NESTEROV_MODE:  nest_ff <= csr_wdata[0];
            msgd_pkg::REG_BATCH_COUNT:    bs_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign bs_eff  = (bs_ff == 16'd0) ? 16'd1 : bs_ff;
   assign lw_prod = 34'(lr_ff) * 34'(wd_ff);

   // coefficient divider: three quotients by the batch size, one bit a cycle
   always_comb begin
      logic [16:0] t;
      logic        ge;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      dirty_in = csr_we | (dirty_ff & (state_ff != ST_IDLE));
      for (int k = 0; k < 3; k++) begin
         dvd_in[k] = dvd_ff[k];
         rem_in[k] = rem_ff[k];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (dirty_ff) begin
               state_in  = ST_RUN;
               cnt_in    = 5'd0;
               dvd_in[0] = CW'(lw_prod >> FRAC_BITS);
               dvd_in[1] = CW'(gam_ff);
               dvd_in[2] = CW'(lr_ff);
               for (int k = 0; k < 3; k++) begin
                  rem_in[k] = 16'd0;
               end
            end
         end
         ST_RUN: begin
            for (int k = 0; k < 3; k++) begin
               t         = {rem_ff[k], dvd_ff[k][CW-1]};
               ge        = t >= {1'b0, bs_eff};
               rem_in[k] = ge ? 16'(t - {1'b0, bs_eff}) : t[15:0];
               dvd_in[k] = {dvd_ff[k][CW-2:0], ge};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(CW - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dirty_ff <= 1'b1;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         dvd_ff[k] <= dvd_in[k];
         rem_ff[k] <= rem_in[k];
      end
   end

   assign coef.step_size       = lr_ff;
   assign coef.momentum_gamma  = gam_ff;
   assign coef.decay_coef      = dvd_ff[0];
   assign coef.gamma_per_batch = dvd_ff[1][16:0];
   assign coef.rate_per_batch  = dvd_ff[2][16:0];
   assign coef.batch_count     = bs_eff;
   assign coef.nesterov_mode   = nest_ff;

   assign req_stall = queue_full | dirty_ff | (state_ff != ST_IDLE) | clear_busy;
   assign push      = req_valid & ~req_stall;

   // index modulo store depth by reciprocal multiplication
   assign w_prod = 26'(req_data.elem_index) * 26'(W_MUL);
   assign b_prod = 26'(req_data.elem_index) * 26'(B_MUL);
   assign w_quot = 12'(w_prod >> W_SH);
   assign b_quot = 12'(b_prod >> B_SH);
   assign w_slot = 17'(29'(req_data.elem_index) - 29'(w_quot) * 29'(W_MOD));
   assign b_slot = 17'(29'(req_data.elem_index) - 29'(b_quot) * 29'(B_MOD));

   assign slot_wide = req_data.is_bias ? b_slot : w_slot;
   assign push_item.req  = req_data;
   assign push_item.slot = slot_wide[15:0];

endmodule

[sv/msgd_queue.sv]
module msgd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  msgd_pkg::item_type push_item,
   input  logic               pop,
   output logic               empty,
   output logic               full,
   output msgd_pkg::item_type head
);

   msgd_pkg::item_type mem_ff[4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= 2'd0;
         rp_ff    <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + 2'd1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 2'd1;
         end
         count_ff <= count_ff + {2'd0, push} - {2'd0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_item;
      end
   end

   assign empty = count_ff == 3'd0;
   assign full  = count_ff == 3'd4;
   assign head  = mem_ff[rp_ff];

endmodule

[sv/msgd_back.sv]
module msgd_back #(
   parameter int WEIGHT_ENTRIES = 4096,
   parameter int BIAS_ENTRIES   = 256,
   parameter int FRAC_BITS      = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  msgd_pkg::coef_type coef,
   input  logic               empty,
   input  msgd_pkg::item_type head,
   output logic               pop,
   output logic               clear_busy,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output msgd_pkg::rsp_type  rsp_data
);

   localparam int WA    = (WEIGHT_ENTRIES > 1) ? $clog2(WEIGHT_ENTRIES) : 1;
   localparam int BA    = (BIAS_ENTRIES > 1) ? $clog2(BIAS_ENTRIES) : 1;
   localparam int CLR_N = (WEIGHT_ENTRIES > BIAS_ENTRIES) ? WEIGHT_ENTRIES : BIAS_ENTRIES;
   localparam int CLR_W = $clog2(CLR_N) + 1;
   localparam int NS    = 32;

   logic signed [31:0] wmem[WEIGHT_ENTRIES];
   logic signed [31:0] bmem[BIAS_ENTRIES];

   logic             clr_busy_ff;
   logic [CLR_W-1:0] clr_cnt_ff;
   logic             en;

   logic               s1_valid_ff;
   msgd_pkg::item_type s1_item_ff;
   logic signed [31:0] w_rd_ff, b_rd_ff;
   logic signed [31:0] slot_v;

   logic               s2_valid_ff;
   msgd_pkg::item_type s2_item_ff;
   logic signed [50:0] s2_gs_ff, s2_lg_ff, s2_lbg_ff;
   logic signed [57:0] s2_cw_ff;
   logic signed [31:0] v_s2, base_s2;

   logic               lw_valid_ff;
   logic               lw_bias_ff;
   logic [15:0]        lw_slot_ff;
   logic signed [31:0] lw_v_ff;

   logic               s3_valid_ff;
   logic [11:0]        s3_idx_ff;
   logic signed [31:0] s3_v_ff, s3_base_ff;
   logic signed [50:0] s3_lbg_ff;

   logic               s4_valid_ff;
   logic [11:0]        s4_idx_ff;
   logic signed [31:0] s4_v_ff, s4_base_ff;
   logic signed [50:0] s4_gbv_ff, s4_lbg_ff;
   logic signed [31:0] nest_res;

   logic               d_valid_ff[NS+1];
   logic [11:0]        d_idx_ff[NS+1];
   logic signed [31:0] d_base_ff[NS+1];
   logic signed [31:0] d_nres_ff[NS+1];
   logic               d_neg_ff[NS+1];
   logic [31:0]        d_dvd_ff[NS+1];
   logic [15:0]        d_rem_ff[NS+1];

   logic signed [32:0] quot;
   logic signed [31:0] plain_res;

   logic               rsp_valid_ff;
   msgd_pkg::rsp_type  rsp_data_ff;

   assign en         = ~rsp_valid_ff | ~rsp_stall;
   assign pop        = en & ~empty & ~clr_busy_ff;
   assign clear_busy = clr_busy_ff;

   // clearing pass over both velocity stores after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == CLR_W'(CLR_N - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         if (clr_cnt_ff < CLR_W'(WEIGHT_ENTRIES)) begin
            wmem[clr_cnt_ff[WA-1:0]] <= '0;
         end
         if (clr_cnt_ff < CLR_W'(BIAS_ENTRIES)) begin
            bmem[clr_cnt_ff[BA-1:0]] <= '0;
         end
      end else if (en && s2_valid_ff) begin
         if (s2_item_ff.req.is_bias) begin
            bmem[s2_item_ff.slot[BA-1:0]] <= v_s2;
         end else begin
            wmem[s2_item_ff.slot[WA-1:0]] <= v_s2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_rd_ff <= wmem[head.slot[WA-1:0]];
         b_rd_ff <= bmem[head.slot[BA-1:0]];
      end
   end

   // newest velocity: item ahead in flight, then last write, then store
   always_comb begin
      priority if (s2_valid_ff && s2_item_ff.req.is_bias == s1_item_ff.req.is_bias
                   && s2_item_ff.slot == s1_item_ff.slot) begin
         slot_v = v_s2;
      end else if (lw_valid_ff && lw_bias_ff == s1_item_ff.req.is_bias
                   && lw_slot_ff == s1_item_ff.slot) begin
         slot_v = lw_v_ff;
      end else if (s1_item_ff.req.is_bias) begin
         slot_v = b_rd_ff;
      end else begin
         slot_v = w_rd_ff;
      end
   end

   assign v_s2 = msgd_pkg::sat32(64'(s2_gs_ff >>> FRAC_BITS) - 64'(s2_lg_ff >>> FRAC_BITS));
   assign base_s2 = s2_item_ff.req.is_bias ? s2_item_ff.req.param_value
      : msgd_pkg::sat32(64'(s2_item_ff.req.param_value) - 64'(s2_cw_ff >>> FRAC_BITS));

   assign nest_res = msgd_pkg::sat32(64'(s4_base_ff) + 64'(s4_gbv_ff >>> FRAC_BITS)
                                     - 64'(s4_lbg_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         lw_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= NS; k++) begin
            d_valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff;
         lw_valid_ff  <= s2_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         d_valid_ff[0] <= s4_valid_ff;
         for (int k = 0; k < NS; k++) begin
            d_valid_ff[k+1] <= d_valid_ff[k];
         end
         rsp_valid_ff <= d_valid_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      logic [16:0] t;
      logic        ge;
      if (en) begin
         s1_item_ff <= head;

         s2_item_ff <= s1_item_ff;
         s2_gs_ff   <= 51'($signed({1'b0, coef.momentum_gamma})) * 51'(slot_v);
         s2_lg_ff   <= 51'($signed({1'b0, coef.step_size}))
                       * 51'(s1_item_ff.req.grad_value);
         s2_lbg_ff  <= 51'($signed({1'b0, coef.rate_per_batch}))
                       * 51'(s1_item_ff.req.grad_value);
         s2_cw_ff   <= 58'($signed({1'b0, coef.decay_coef}))
                       * 58'(s1_item_ff.req.param_value);

         lw_bias_ff <= s2_item_ff.req.is_bias;
         lw_slot_ff <= s2_item_ff.slot;
         lw_v_ff    <= v_s2;

         s3_idx_ff  <= s2_item_ff.req.elem_index;
         s3_v_ff    <= v_s2;
         s3_base_ff <= base_s2;
         s3_lbg_ff  <= s2_lbg_ff >>> FRAC_BITS;

         s4_idx_ff  <= s3_idx_ff;
         s4_v_ff    <= s3_v_ff;
         s4_base_ff <= s3_base_ff;
         s4_lbg_ff  <= s3_lbg_ff;
         s4_gbv_ff  <= 51'($signed({1'b0, coef.gamma_per_batch})) * 51'(s3_v_ff);

         d_idx_ff[0]  <= s4_idx_ff;
         d_base_ff[0] <= s4_base_ff;
         d_nres_ff[0] <= nest_res;
         d_neg_ff[0]  <= s4_v_ff[31];
         d_dvd_ff[0]  <= s4_v_ff[31] ? 32'(-33'(s4_v_ff)) : s4_v_ff;
         d_rem_ff[0]  <= 16'd0;

         for (int k = 0; k < NS; k++) begin
            t  = {d_rem_ff[k], d_dvd_ff[k][31]};
            ge = t >= {1'b0, coef.batch_count};
            d_idx_ff[k+1]  <= d_idx_ff[k];
            d_base_ff[k+1] <= d_base_ff[k];
            d_nres_ff[k+1] <= d_nres_ff[k];
            d_neg_ff[k+1]  <= d_neg_ff[k];
            d_rem_ff[k+1]  <= ge ? 16'(t - {1'b0, coef.batch_count}) : t[15:0];
            d_dvd_ff[k+1]  <= {d_dvd_ff[k][30:0], ge};
         end

         rsp_data_ff.out_index     <= d_idx_ff[NS];
         rsp_data_ff.updated_value <= coef.nesterov_mode ? d_nres_ff[NS] : plain_res;
      end
   end

   assign quot = d_neg_ff[NS] ? -$signed({1'b0, d_dvd_ff[NS]}) : $signed({1'b0, d_dvd_ff[NS]});
   assign plain_res = msgd_pkg::sat32(64'(d_base_ff[NS]) + 64'(quot));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/momentum_sgd_update.sv]
// Per-element SGD with momentum, plain or Nesterov, in signed fixed point.
// One request is taken per cycle when req_stall is low; each gives one
// response, passing through a 32-stage pipelined divider that forms v/bs.
// Requests queue (four deep) ahead of the update pipeline, which holds only
// when the response is stalled. After reset a clearing pass zeroes the
// velocity stores, and after reset or any register write the batch-scaled
// coefficients are rebuilt; requests are stalled meanwhile.
module momentum_sgd_update #(
   parameter int WEIGHT_ENTRIES = 4096,
   parameter int BIAS_ENTRIES   = 256,
   parameter int FRAC_BITS      = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  msgd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output msgd_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [16:0]       csr_wdata
);

   logic               queue_full, queue_empty, clear_busy, push, pop;
   msgd_pkg::item_type push_item, head;
   msgd_pkg::coef_type coef;

   msgd_front #(
      .WEIGHT_ENTRIES(WEIGHT_ENTRIES),
      .BIAS_ENTRIES  (BIAS_ENTRIES),
      .FRAC_BITS     (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .queue_full(queue_full),
      .clear_busy(clear_busy),
      .push      (push),
      .push_item (push_item),
      .coef      (coef)
   );

   msgd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .pop      (pop),
      .empty    (queue_empty),
      .full     (queue_full),
      .head     (head)
   );

   msgd_back #(
      .WEIGHT_ENTRIES(WEIGHT_ENTRIES),
      .BIAS_ENTRIES  (BIAS_ENTRIES),
      .FRAC_BITS     (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef),
      .empty     (queue_empty),
      .head      (head),
      .pop       (pop),
      .clear_busy(clear_busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[sv/msgd_checker.sv]
`include "momentum_sgd_update_assert.svh"

module msgd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input msgd_pkg::rsp_type rsp_data
);

   `MSGD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `MSGD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))
   `MSGD_ASSERT_AFTER(a_rsp_clear, clock, reset, !rsp_valid)
   `MSGD_ASSERT_AFTER(a_clear_stall, clock, reset, req_stall)

endmodule

bind momentum_sgd_update msgd_checker u_checker (
   .clock    (clock),
   .reset    (reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

[bench/momentum_sgd_update_tb.sv]
module momentum_sgd_update_tb;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 400000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   msgd_pkg::req_type     req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   msgd_pkg::rsp_type     rsp_data;
   logic                  csr_we = 1'b0;
   logic [2:0]            csr_index = '0;
   logic [16:0]           csr_wdata = '0;

   momentum_sgd_update uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow registers and velocity stores
   logic [16:0] lr_q = msgd_pkg::RST_STEP_SIZE;
   logic [16:0] wd_q = msgd_pkg::RST_DECAY_FACTOR;
   logic [16:0] gamma_q = msgd_pkg::RST_MOMENTUM_GAMMA;
   logic        nest_q = 1'b0;
   logic [15:0] bs_q = msgd_pkg::RST_BATCH_COUNT;
   logic signed [31:0] w_vel [4096];
   logic signed [31:0] b_vel [256];

   msgd_pkg::rsp_type pending_updates[$];
   msgd_pkg::rsp_type due;
   int  errors = 0;
   int  cycles = 0;
   bit  gaps_on = 1'b0;
   int  burst_left = 0;
   int  hold_cycles = 0;
   bit  rx_stall_on = 1'b0;
   logic [15:0] rx_pattern = '0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic longint fx_mul(longint a, longint b);
      return (a * b) >>> 16;
   endfunction

   function automatic longint clamp32(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic msgd_pkg::rsp_type predict_update(msgd_pkg::req_type r);
      longint w, g, lr, gam, bs, vold, v, base, res, coef;
      msgd_pkg::rsp_type o;
      w = longint'(r.param_value);
      g = longint'(r.grad_value);
      lr = longint'(lr_q);
      gam = longint'(gamma_q);
      bs = (bs_q == 0) ? 1 : longint'(bs_q);
      vold = r.is_bias ? longint'(b_vel[r.elem_index[7:0]]) : longint'(w_vel[r.elem_index]);
      if (r.is_bias) begin
         base = w;
      end else begin
         coef = fx_mul(lr, longint'(wd_q)) / bs;
         base = clamp32(w - fx_mul(coef, w));
      end
      v = clamp32(fx_mul(gam, vold) - fx_mul(lr, g));
      if (r.is_bias) b_vel[r.elem_index[7:0]] = v[31:0];
      else w_vel[r.elem_index] = v[31:0];
      if (nest_q) res = base + fx_mul(gam / bs, v) - fx_mul(lr / bs, g);
      else res = base + v / bs;
      o.updated_value = 32'(clamp32(res));
      o.out_index = r.elem_index;
      return o;
   endfunction

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_updates.size() == 0) begin
            $error("response with nothing outstanding: index %0d", rsp_data.out_index);
            errors++;
         end else begin
            due = pending_updates.pop_front();
            if (rsp_data.updated_value !== due.updated_value) begin
               $error("updated_value: expected %0d, got %0d",
                      due.updated_value, rsp_data.updated_value);
               errors++;
            end
            if (rsp_data.out_index !== due.out_index) begin
               $error("out_index: expected %0d, got %0d", due.out_index, rsp_data.out_index);
               errors++;
            end
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (rx_stall_on) begin
         if (cycles % 16 == 0) rx_pattern <= 16'($urandom);
         rsp_stall <= rx_pattern[cycles % 16];
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_update(msgd_pkg::req_type r);
      int gap;
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(1, 6);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left--;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      pending_updates.push_back(predict_update(r));
   endtask

   task automatic go_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      go_quiet();
      while (pending_updates.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [16:0] val);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         msgd_pkg::REG_STEP_SIZE:      lr_q = val;
         msgd_pkg::REG_DECAY_FACTOR:   wd_q = val;
         msgd_pkg::REG_MOMENTUM_GAMMA: gamma_q = val;
         msgd_pkg::REG_NESTEROV_MODE:  nest_q = val[0];
         msgd_pkg::REG_BATCH_COUNT:    bs_q = val[15:0];
         default: ;
      endcase
   endtask

   function automatic msgd_pkg::req_type make_req(bit b, int idx, int w, int g);
      msgd_pkg::req_type r;
      r.is_bias = b;
      r.elem_index = 12'(idx);
      r.param_value = w;
      r.grad_value = g;
      return r;
   endfunction

   function automatic int rand_q();
      case ($urandom_range(0, 3))
         0: return int'($urandom);
         1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return int'($urandom_range(0, 400000)) - 200000;
      endcase
   endfunction

   function automatic msgd_pkg::req_type rand_req();
      int idx;
      idx = $urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, 15);
      return make_req(1'($urandom_range(0, 1)), idx, rand_q(), rand_q());
   endfunction

   task automatic test_directed();
      send_update(make_req(1'b0, 0, 32'sh7fffffff, 32'sh80000000));
      send_update(make_req(1'b0, 0, 32'sh80000000, 32'sh7fffffff));
      send_update(make_req(1'b1, 4095, 32'sh7fffffff, 32'sh7fffffff));
      send_update(make_req(1'b1, 255, 0, 32'sh80000000));
      // bias index beyond its store aliases onto a low entry
      send_update(make_req(1'b1, 256 + 5, 65536, 65536));
      send_update(make_req(1'b1, 5, 65536, -65536));
      write_reg(msgd_pkg::REG_BATCH_COUNT, 17'd0);
      send_update(make_req(1'b0, 7, 123456, -98765));
      write_reg(msgd_pkg::REG_BATCH_COUNT, 17'd65535);
      write_reg(msgd_pkg::REG_DECAY_FACTOR, 17'd65536);
      write_reg(msgd_pkg::REG_STEP_SIZE, 17'd65536);
      send_update(make_req(1'b0, 7, 32'sh7fffffff, 32'sh80000000));
      write_reg(msgd_pkg::REG_NESTEROV_MODE, 17'd1);
      send_update(make_req(1'b0, 7, -5, 32'sh7fffffff));
      send_update(make_req(1'b1, 4095, 32'sh80000000, 32'sh80000000));
      // learning rate above 1.0, no momentum
      write_reg(msgd_pkg::REG_STEP_SIZE, 17'h1ffff);
      write_reg(msgd_pkg::REG_MOMENTUM_GAMMA, 17'd0);
      write_reg(msgd_pkg::REG_BATCH_COUNT, 17'd1);
      send_update(make_req(1'b0, 4095, 32'sh7fffffff, 32'sh80000000));
      send_update(make_req(1'b0, 4095, 0, 32'sh7fffffff));
      write_reg(msgd_pkg::REG_MOMENTUM_GAMMA, 17'h1ffff);
      write_reg(REG_UNUSED, 17'h1ffff);
      send_update(make_req(1'b0, 4095, 1, 1));
      write_reg(msgd_pkg::REG_NESTEROV_MODE, 17'd0);
      write_reg(msgd_pkg::REG_DECAY_FACTOR, 17'd0);
      send_update(make_req(1'b0, 4095, -1, -1));
      drain();
   endtask

   task automatic test_random();
      for (int ph = 0; ph < 7; ph++) begin
         write_reg(msgd_pkg::REG_STEP_SIZE,
                   ph == 0 ? 17'd0 : 17'($urandom_range(0, 131071)));
         write_reg(msgd_pkg::REG_DECAY_FACTOR, 17'($urandom_range(0, 131071)));
         write_reg(msgd_pkg::REG_MOMENTUM_GAMMA,
                   ph == 1 ? 17'd65536 : 17'($urandom_range(0, 65536)));
         write_reg(msgd_pkg::REG_NESTEROV_MODE, 17'(ph % 2));
         write_reg(msgd_pkg::REG_BATCH_COUNT, ph < 3 ? 17'($urandom_range(0, 4)) :
                                              17'($urandom_range(0, 65535)));
         gaps_on = (ph != 2);
         rx_stall_on = (ph != 4);
         repeat (240) send_update(rand_req());
      end
      drain();
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      rx_stall_on = 1'b1;
      hold_cycles = 300;
      repeat (60) send_update(rand_req());
      // pause until every response is back, then resume
      drain();
      repeat (30) send_update(rand_req());
      drain();
   endtask

   initial begin
      for (int i = 0; i < 4096; i++) w_vel[i] = '0;
      for (int i = 0; i < 256; i++) b_vel[i] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random();
      test_backpressure();
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
